// ===== hdl/mac_address_lease_lookup_macros.svh =====
// assertion macros for the mac address lease lookup checker
`ifndef MAC_ADDRESS_LEASE_LOOKUP_MACROS_SVH
`define MAC_ADDRESS_LEASE_LOOKUP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MALL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define MALL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/mall_pkg.sv =====
// shared constants for the mac address lease lookup block
`timescale 1ns / 1ps

package mall_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 64;

    localparam int MAC_W    = 48;
    localparam int IP_W     = 32;
    localparam int PREFIX_W = 24;
    localparam int HOST_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_PREFIX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_LAST   = 2'd2;

    localparam logic [PREFIX_W-1:0] POOL_PREFIX_RESET = 24'hC0A804;
    localparam logic [HOST_W-1:0]   POOL_FIRST_RESET  = 8'd100;
    localparam logic [HOST_W-1:0]   POOL_LAST_RESET   = 8'd200;

endpackage

// ===== hdl/mall_ram.sv =====
// generic single-clock ram with one write port and a registered read port
`timescale 1ns / 1ps

module mall_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mac_address_lease_lookup.sv =====
// top level: mac to ipv4 binding table with a round-robin fallback pool
// a load or an empty-table lookup is settled in ST_IDLE; ST_FINISH then moves its result to the output register;
// a lookup scans the stored entries in ST_SCAN up to the first match, at most TABLE_DEPTH, before ST_FINISH
// one request in flight, one entry read per cycle; no new request is taken until ST_FINISH is done
// the result sits in an output register, so the next request is taken while it waits
// reset (async, active low) empties the table and restores pool registers; no clearing pass
`timescale 1ns / 1ps

module mac_address_lease_lookup #(
    parameter int TABLE_DEPTH = mall_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [mall_pkg::MAC_W-1:0]     mac,
    input  logic [mall_pkg::IP_W-1:0]      entry_ip,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mall_pkg::IP_W-1:0]      assigned_ip,
    output logic                           from_table,
    output logic                           load_accepted,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mall_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mall_pkg::PREFIX_W-1:0]  cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = mall_pkg::MAC_W + mall_pkg::IP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [mall_pkg::HOST_W-1:0]     pool_next_reg, pool_next_next;
    logic [mall_pkg::PREFIX_W-1:0]   prefix_reg, prefix_next;
    logic [mall_pkg::HOST_W-1:0]     first_reg, first_next;
    logic [mall_pkg::HOST_W-1:0]     last_reg, last_next;
    logic [AW-1:0]                   chk_reg, chk_next;
    logic [mall_pkg::MAC_W-1:0]      key_reg, key_next;
    logic [mall_pkg::IP_W-1:0]       res_ip_reg, res_ip_next;
    logic                            res_hit_reg, res_hit_next;
    logic                            res_load_reg, res_load_next;
    logic                            out_valid_reg, out_valid_next;
    logic [mall_pkg::IP_W-1:0]       out_ip_reg, out_ip_next;
    logic                            out_hit_reg, out_hit_next;
    logic                            out_load_reg, out_load_next;

    logic                            wr_en;
    logic [EW-1:0]                   wr_data;
    logic                            rd_en;
    logic [AW-1:0]                   rd_addr;
    logic [EW-1:0]                   rd_data;

    logic [mall_pkg::HOST_W:0]       pool_sum;
    logic [mall_pkg::HOST_W-1:0]     pool_adv;
    logic [mall_pkg::IP_W-1:0]       miss_ip;

    mall_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign wr_data = {mac, entry_ip};

    // pool address and its round-robin advance
    assign miss_ip  = {prefix_reg, pool_next_reg};
    assign pool_sum = {1'b0, pool_next_reg} + {{mall_pkg::HOST_W{1'b0}}, 1'b1};
    assign pool_adv = (pool_sum > {1'b0, last_reg} || pool_sum[mall_pkg::HOST_W])
                      ? first_reg : pool_sum[mall_pkg::HOST_W-1:0];

    assign in_ready      = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign assigned_ip   = out_ip_reg;
    assign from_table    = out_hit_reg;
    assign load_accepted = out_load_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pool_next_next = pool_next_reg;
        prefix_next    = prefix_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        chk_next       = chk_reg;
        key_next       = key_reg;
        res_ip_next    = res_ip_reg;
        res_hit_next   = res_hit_reg;
        res_load_next  = res_load_reg;
        out_valid_next = out_valid_reg;
        out_ip_next    = out_ip_reg;
        out_hit_next   = out_hit_reg;
        out_load_next  = out_load_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = chk_reg + AW'(1);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                mall_pkg::CFG_POOL_PREFIX: prefix_next = cfg_data;
                mall_pkg::CFG_POOL_FIRST:  first_next  = cfg_data[mall_pkg::HOST_W-1:0];
                mall_pkg::CFG_POOL_LAST:   last_next   = cfg_data[mall_pkg::HOST_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_ip_next   = '0;
                    res_hit_next  = 1'b0;
                    res_load_next = 1'b0;
                    key_next      = mac;
                    state_next    = ST_FINISH;
                    if (opcode == mall_pkg::OP_LOAD)
                    begin
                        if (count_reg < CW'(TABLE_DEPTH))
                        begin
                            wr_en         = 1'b1;
                            count_next    = count_reg + CW'(1);
                            res_load_next = 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_ip_next    = miss_ip;
                        pool_next_next = pool_adv;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        chk_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // rd_data holds the entry at chk_reg; the next entry is fetched meanwhile if the scan goes on
                if (rd_data[EW-1:mall_pkg::IP_W] == key_reg)
                begin
                    res_ip_next  = rd_data[mall_pkg::IP_W-1:0];
                    res_hit_next = 1'b1;
                    state_next   = ST_FINISH;
                end
                else if (CW'(chk_reg) + CW'(1) == count_reg)
                begin
                    res_ip_next    = miss_ip;
                    pool_next_next = pool_adv;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    chk_next = chk_reg + AW'(1);
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_ip_next    = res_ip_reg;
                    out_hit_next   = res_hit_reg;
                    out_load_next  = res_load_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pool_next_reg <= mall_pkg::POOL_FIRST_RESET;
            prefix_reg    <= mall_pkg::POOL_PREFIX_RESET;
            first_reg     <= mall_pkg::POOL_FIRST_RESET;
            last_reg      <= mall_pkg::POOL_LAST_RESET;
            chk_reg       <= '0;
            key_reg       <= '0;
            res_ip_reg    <= '0;
            res_hit_reg   <= 1'b0;
            res_load_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ip_reg    <= '0;
            out_hit_reg   <= 1'b0;
            out_load_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pool_next_reg <= pool_next_next;
            prefix_reg    <= prefix_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            chk_reg       <= chk_next;
            key_reg       <= key_next;
            res_ip_reg    <= res_ip_next;
            res_hit_reg   <= res_hit_next;
            res_load_reg  <= res_load_next;
            out_valid_reg <= out_valid_next;
            out_ip_reg    <= out_ip_next;
            out_hit_reg   <= out_hit_next;
            out_load_reg  <= out_load_next;
        end
    end

endmodule

// ===== hdl/mall_checker.sv =====
// port-level checker for the mac address lease lookup block, with its bind
`timescale 1ns / 1ps
`include "mac_address_lease_lookup_macros.svh"

module mall_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [mall_pkg::IP_W-1:0]      assigned_ip,
    input logic                           from_table,
    input logic                           load_accepted
);

    // a stalled result keeps its payload
    `MALL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(assigned_ip) && $stable(from_table) && $stable(load_accepted))

    // a stored load answers with a zero address and no table hit
    `MALL_ASSERT_NOW(a_load_result, out_valid && load_accepted,
        !from_table && assigned_ip == '0)

    // one request at a time: no new request right after one is taken
    `MALL_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // a new result only appears while a request is being worked on
    `MALL_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(!in_ready))

endmodule

bind mac_address_lease_lookup mall_checker u_mall_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .assigned_ip   (assigned_ip),
    .from_table    (from_table),
    .load_accepted (load_accepted)
);
